FILE: sv/swkt_pkg.sv
// swkt_pkg: shared constants, state encoding and control structs
// for the sliding window key tally unit; no dependencies
package swkt_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int KEY_COUNT_DEF   = 64;
    localparam int CLIENT_IDS_DEF  = 1024;

    localparam int TIME_W    = 48;
    localparam int KEY_IN_W  = 6;
    localparam int CLI_IN_W  = 10;
    localparam int AMT_W     = 16;
    localparam int CNT_OUT_W = 11;
    localparam int SUM_OUT_W = 26;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 3;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 32'd86400;
    localparam logic             REG_WINDOW   = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_EXP_UPD,
        ST_KEY_RD,
        ST_KEY_UPD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic reduce;
        logic exp_rd;
        logic exp_issue;
        logic exp_upd;
        logic key_rd;
        logic key_upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic fill_zero;
        logic expired;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/swkt_modred.sv
// swkt_modred: two-step reduction of an index modulo a constant
// (reciprocal multiply, then one correction; a plain copy when C >= 2**W); no package needed
module swkt_modred #(
    parameter int W  = 6,
    parameter int C  = 64,
    parameter int RW = 6
) (
    input  logic          clk,
    input  logic          capture,
    input  logic          reduce,
    input  logic [W-1:0]  x,
    output logic [RW-1:0] r
);

    logic [RW-1:0] r_reg;
    logic [W-1:0]  x_reg;

    assign r = r_reg;

    generate
        if (C >= 2**W) begin : g_ident
            always_ff @(posedge clk)
            begin
                if (capture)
                begin
                    x_reg <= x;
                end
                if (reduce)
                begin
                    r_reg <= RW'(x_reg);
                end
            end
        end else begin : g_recip
            localparam int unsigned M = (2**W) / C;
            logic [W:0]     q_reg;
            logic [2*W:0]   prod;
            logic [2*W:0]   qc;
            logic [W-1:0]   rem;
            logic [W-1:0]   r_next;

            assign prod   = (2*W+1)'(x) * (2*W+1)'(M);
            assign qc     = (2*W+1)'(q_reg) * (2*W+1)'(C);
            assign rem    = x_reg - qc[W-1:0];
            assign r_next = (rem >= W'(C)) ? rem - W'(C) : rem;

            always_ff @(posedge clk)
            begin
                if (capture)
                begin
                    x_reg <= x;
                    q_reg <= prod[2*W:W];
                end
                if (reduce)
                begin
                    r_reg <= RW'(r_next);
                end
            end
        end
    endgenerate

endmodule

FILE: sv/swkt_ctrl.sv
// swkt_ctrl: sequencer for clearing, expiry, insert or query, and result transfer
// depends on swkt_pkg
module swkt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  swkt_pkg::sts_t sts,
    output swkt_pkg::cmd_t cmd
);

    swkt_pkg::state_t state_reg;
    swkt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swkt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            swkt_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = swkt_pkg::ST_IDLE;
                end
            end
            swkt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = swkt_pkg::ST_REDUCE;
                end
            end
            swkt_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = sts.is_query ? swkt_pkg::ST_KEY_RD : swkt_pkg::ST_EXP_RD;
            end
            swkt_pkg::ST_EXP_RD:
            begin
                if (sts.fill_zero)
                begin
                    state_next = swkt_pkg::ST_KEY_RD;
                end
                else
                begin
                    cmd.exp_rd = 1'b1;
                    state_next = swkt_pkg::ST_EXP_CHK;
                end
            end
            swkt_pkg::ST_EXP_CHK:
            begin
                if (sts.expired)
                begin
                    cmd.exp_issue = 1'b1;
                    state_next    = swkt_pkg::ST_EXP_UPD;
                end
                else
                begin
                    state_next = swkt_pkg::ST_KEY_RD;
                end
            end
            swkt_pkg::ST_EXP_UPD:
            begin
                cmd.exp_upd = 1'b1;
                state_next  = swkt_pkg::ST_EXP_RD;
            end
            swkt_pkg::ST_KEY_RD:
            begin
                cmd.key_rd = 1'b1;
                state_next = swkt_pkg::ST_KEY_UPD;
            end
            swkt_pkg::ST_KEY_UPD:
            begin
                cmd.key_upd = 1'b1;
                state_next  = swkt_pkg::ST_RESULT;
            end
            swkt_pkg::ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = swkt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swkt_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: sv/swkt_dp.sv
// swkt_dp: record queue, pair count and per-key tables, expiry compare,
// result and output registers; depends on swkt_pkg and swkt_modred
module swkt_dp #(
    parameter int QUEUE_DEPTH = swkt_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_COUNT   = swkt_pkg::KEY_COUNT_DEF,
    parameter int CLIENT_IDS  = swkt_pkg::CLIENT_IDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  swkt_pkg::cmd_t                    cmd,
    output swkt_pkg::sts_t                    sts,
    input  logic [swkt_pkg::CFG_W-1:0]        window,
    input  logic                              op,
    input  logic signed [swkt_pkg::TIME_W-1:0] event_time,
    input  logic [swkt_pkg::KEY_IN_W-1:0]     key_index,
    input  logic [swkt_pkg::CLI_IN_W-1:0]     client_index,
    input  logic [swkt_pkg::AMT_W-1:0]        amount,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [swkt_pkg::CNT_OUT_W-1:0]    distinct_clients,
    output logic [swkt_pkg::SUM_OUT_W-1:0]    amount_total
);

    localparam int TW     = swkt_pkg::TIME_W;
    localparam int AW     = swkt_pkg::AMT_W;
    localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int KA_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CA_W   = $clog2(CLIENT_IDS);
    localparam int PDEPTH = KEY_COUNT * CLIENT_IDS;
    localparam int PA_W   = $clog2(PDEPTH);
    localparam int CNT_W  = FW;
    localparam int SUM_W  = AW + FW;
    localparam int ENT_W  = TW + KA_W + CA_W + AW;
    localparam int LW     = TW + 2;
    localparam int CXW    = (CNT_W > swkt_pkg::CNT_OUT_W) ? CNT_W : swkt_pkg::CNT_OUT_W;
    localparam int SXW    = (SUM_W > swkt_pkg::SUM_OUT_W) ? SUM_W : swkt_pkg::SUM_OUT_W;

    logic [ENT_W-1:0] q_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0] pair_mem [PDEPTH];
    logic [CNT_W-1:0] kc_mem [KEY_COUNT];
    logic [SUM_W-1:0] ks_mem [KEY_COUNT];

    logic [ENT_W-1:0] q_rd_reg;
    logic [CNT_W-1:0] pair_rd_reg;
    logic [CNT_W-1:0] kc_rd_reg;
    logic [SUM_W-1:0] ks_rd_reg;

    logic                  op_reg;
    logic signed [TW-1:0]  time_reg;
    logic [AW-1:0]         amt_reg;
    logic signed [LW-1:0]  limit_reg;
    logic [PA_W-1:0]       clr_idx_reg;
    logic [QA_W-1:0]       head_reg;
    logic [FW-1:0]         fill_reg;
    logic                  res_status_reg;
    logic [swkt_pkg::CNT_OUT_W-1:0] res_cnt_reg;
    logic [swkt_pkg::SUM_OUT_W-1:0] res_sum_reg;
    logic                  out_valid_reg;
    logic                  status_reg;
    logic [swkt_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic [swkt_pkg::SUM_OUT_W-1:0] sum_out_reg;

    logic [KA_W-1:0]  key_r;
    logic [CA_W-1:0]  client_r;

    swkt_modred #(
        .W  (swkt_pkg::KEY_IN_W),
        .C  (KEY_COUNT),
        .RW (KA_W)
    ) u_key_mod (
        .clk     (clk),
        .capture (cmd.capture),
        .reduce  (cmd.reduce),
        .x       (key_index),
        .r       (key_r)
    );

    swkt_modred #(
        .W  (swkt_pkg::CLI_IN_W),
        .C  (CLIENT_IDS),
        .RW (CA_W)
    ) u_cli_mod (
        .clk     (clk),
        .capture (cmd.capture),
        .reduce  (cmd.reduce),
        .x       (client_index),
        .r       (client_r)
    );

    // queue entry fields
    logic signed [TW-1:0] e_time;
    logic [KA_W-1:0]      e_key;
    logic [CA_W-1:0]      e_client;
    logic [AW-1:0]        e_amt;
    logic [PA_W-1:0]      e_slot;
    logic [PA_W-1:0]      slot;

    assign e_time   = $signed(q_rd_reg[ENT_W-1 -: TW]);
    assign e_key    = q_rd_reg[AW+CA_W +: KA_W];
    assign e_client = q_rd_reg[AW +: CA_W];
    assign e_amt    = q_rd_reg[AW-1:0];
    assign e_slot   = PA_W'(e_key) * PA_W'(CLIENT_IDS) + PA_W'(e_client);
    assign slot     = PA_W'(key_r) * PA_W'(CLIENT_IDS) + PA_W'(client_r);

    logic           full;
    logic           do_ins;
    logic [FW:0]    tail_sum;
    logic [FW:0]    tail_wrap;
    logic [QA_W-1:0] tail;
    logic           clr_key;

    assign full      = (fill_reg == FW'(QUEUE_DEPTH));
    assign do_ins    = !op_reg && !full;
    assign tail_sum  = (FW+1)'(head_reg) + (FW+1)'(fill_reg);
    assign tail_wrap = (tail_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                       tail_sum - (FW+1)'(QUEUE_DEPTH) : tail_sum;
    assign tail      = tail_wrap[QA_W-1:0];
    assign clr_key   = (clr_idx_reg < PA_W'(KEY_COUNT));

    // table update values
    logic [CNT_W-1:0] pair_dec;
    logic [CNT_W-1:0] kc_dec;
    logic [SUM_W-1:0] ks_dec;
    logic [CNT_W-1:0] pair_inc;
    logic [CNT_W-1:0] kc_inc;
    logic [SUM_W-1:0] ks_inc;

    assign pair_dec = (pair_rd_reg != '0) ? pair_rd_reg - 1'b1 : pair_rd_reg;
    assign kc_dec   = (pair_rd_reg == CNT_W'(1) && kc_rd_reg != '0) ?
                      kc_rd_reg - 1'b1 : kc_rd_reg;
    assign ks_dec   = (ks_rd_reg >= SUM_W'(e_amt)) ? ks_rd_reg - SUM_W'(e_amt) : '0;
    assign pair_inc = pair_rd_reg + 1'b1;
    assign kc_inc   = (pair_rd_reg == '0) ? kc_rd_reg + 1'b1 : kc_rd_reg;
    assign ks_inc   = ks_rd_reg + SUM_W'(amt_reg);

    logic             pair_we;
    logic [PA_W-1:0]  pair_waddr;
    logic [CNT_W-1:0] pair_wdata;
    logic [PA_W-1:0]  pair_raddr;
    logic             key_we;
    logic [KA_W-1:0]  key_waddr;
    logic [CNT_W-1:0] kc_wdata;
    logic [SUM_W-1:0] ks_wdata;
    logic [KA_W-1:0]  key_raddr;
    logic             tab_re;

    always_comb
    begin
        pair_we    = 1'b0;
        pair_waddr = slot;
        pair_wdata = pair_inc;
        key_we     = 1'b0;
        key_waddr  = key_r;
        kc_wdata   = kc_inc;
        ks_wdata   = ks_inc;
        if (cmd.clr_step)
        begin
            pair_we    = 1'b1;
            pair_waddr = clr_idx_reg;
            pair_wdata = '0;
            key_we     = clr_key;
            key_waddr  = clr_idx_reg[KA_W-1:0];
            kc_wdata   = '0;
            ks_wdata   = '0;
        end
        else if (cmd.exp_upd)
        begin
            pair_we    = 1'b1;
            pair_waddr = e_slot;
            pair_wdata = pair_dec;
            key_we     = 1'b1;
            key_waddr  = e_key;
            kc_wdata   = kc_dec;
            ks_wdata   = ks_dec;
        end
        else if (cmd.key_upd && do_ins)
        begin
            pair_we = 1'b1;
            key_we  = 1'b1;
        end
    end

    assign tab_re     = cmd.exp_issue || cmd.key_rd;
    assign pair_raddr = cmd.exp_issue ? e_slot : slot;
    assign key_raddr  = cmd.exp_issue ? e_key : key_r;

    always_ff @(posedge clk)
    begin
        if (cmd.key_upd && do_ins)
        begin
            q_mem[tail] <= {time_reg, key_r, client_r, amt_reg};
        end
        if (cmd.exp_rd)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_waddr] <= pair_wdata;
        end
        if (tab_re)
        begin
            pair_rd_reg <= pair_mem[pair_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            kc_mem[key_waddr] <= kc_wdata;
            ks_mem[key_waddr] <= ks_wdata;
        end
        if (tab_re)
        begin
            kc_rd_reg <= kc_mem[key_raddr];
            ks_rd_reg <= ks_mem[key_raddr];
        end
    end

    // result values with saturation
    logic [CNT_W-1:0] res_cnt_w;
    logic [SUM_W-1:0] res_sum_w;
    logic [CXW-1:0]   cnt_x;
    logic [SXW-1:0]   sum_x;

    assign res_cnt_w = do_ins ? kc_inc : kc_rd_reg;
    assign res_sum_w = do_ins ? ks_inc : ks_rd_reg;
    assign cnt_x     = CXW'(res_cnt_w);
    assign sum_x     = SXW'(res_sum_w);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            time_reg <= event_time;
            amt_reg  <= amount;
        end
        if (cmd.reduce)
        begin
            limit_reg <= LW'(time_reg) - $signed({{(LW-swkt_pkg::CFG_W){1'b0}}, window});
        end
        if (cmd.key_upd)
        begin
            res_status_reg <= !op_reg && full;
            res_cnt_reg    <= (cnt_x > CXW'(2047)) ? 11'd2047 : cnt_x[swkt_pkg::CNT_OUT_W-1:0];
            res_sum_reg    <= (sum_x > SXW'(67108863)) ? 26'd67108863 :
                              sum_x[swkt_pkg::SUM_OUT_W-1:0];
        end
        if (cmd.load_out)
        begin
            status_reg  <= res_status_reg;
            cnt_out_reg <= res_cnt_reg;
            sum_out_reg <= res_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.exp_upd)
            begin
                head_reg <= (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            else if (cmd.key_upd && do_ins)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_done  = (clr_idx_reg == PA_W'(PDEPTH - 1));
    assign sts.is_query  = op_reg;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.expired   = (LW'(e_time) <= limit_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign distinct_clients = cnt_out_reg;
    assign amount_total     = sum_out_reg;

endmodule

FILE: sv/sliding_window_key_tally_unit.sv
// sliding_window_key_tally_unit: top level with config register port,
// controller and datapath; depends on swkt_pkg, swkt_ctrl, swkt_dp
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (window_length)
//  input    | in_valid/in_ready    | op, event_time, key_index, client_index, amount
//  output   | out_valid/out_ready  | status, distinct_clients, amount_total
//
// a record steps through reduce, expiry read and check (plus an update per expired queue entry),
// then key read and key update, a read-modify-write of the count tables; a query skips expiry
// after reset a clearing pass zeroes the pair and key tables
// and no input transfer is taken during it
// a finished result waits in the output register while the next item is taken;
// a further result waits in the result registers until the output register frees
module sliding_window_key_tally_unit #(
    parameter int QUEUE_DEPTH = swkt_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_COUNT   = swkt_pkg::KEY_COUNT_DEF,
    parameter int CLIENT_IDS  = swkt_pkg::CLIENT_IDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swkt_pkg::ADDR_W-1:0]        paddr,
    input  logic [swkt_pkg::CFG_W-1:0]         pwdata,
    output logic [swkt_pkg::CFG_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic signed [swkt_pkg::TIME_W-1:0] event_time,
    input  logic [swkt_pkg::KEY_IN_W-1:0]      key_index,
    input  logic [swkt_pkg::CLI_IN_W-1:0]      client_index,
    input  logic [swkt_pkg::AMT_W-1:0]         amount,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               status,
    output logic [swkt_pkg::CNT_OUT_W-1:0]     distinct_clients,
    output logic [swkt_pkg::SUM_OUT_W-1:0]     amount_total
);

    logic [swkt_pkg::CFG_W-1:0] window_reg;
    logic                       reg_sel;
    swkt_pkg::cmd_t             cmd;
    swkt_pkg::sts_t             sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == swkt_pkg::REG_WINDOW);
    assign prdata  = reg_sel ? window_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swkt_pkg::WINDOW_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            window_reg <= pwdata;
        end
    end

    swkt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swkt_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_COUNT   (KEY_COUNT),
        .CLIENT_IDS  (CLIENT_IDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .window           (window_reg),
        .op               (op),
        .event_time       (event_time),
        .key_index        (key_index),
        .client_index     (client_index),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .distinct_clients (distinct_clients),
        .amount_total     (amount_total)
    );

    // after an input transfer the unit stays busy through the reduce state and the read state behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again too soon");

    // a written window reads back
    a_window_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(psel && penable && pwrite && paddr[2] == swkt_pkg::REG_WINDOW) &&
        paddr[2] == swkt_pkg::REG_WINDOW |-> prdata == $past(pwdata))
        else $error("window register readback mismatch");

    // no result right after reset
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

FILE: test/tally_checker.sv
// tally_checker: watches the config, input and output channels of the
// sliding window key tally unit, predicts every result and compares; uses swkt_pkg
module tally_checker
    import swkt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [CFG_W-1:0]         pwdata,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     op,
    input  logic signed [TIME_W-1:0] event_time,
    input  logic [KEY_IN_W-1:0]      key_index,
    input  logic [CLI_IN_W-1:0]      client_index,
    input  logic [AMT_W-1:0]         amount,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     status,
    input  logic [CNT_OUT_W-1:0]     distinct_clients,
    input  logic [SUM_OUT_W-1:0]     amount_total,
    output int                       errors,
    output int                       outstanding
);

    localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * REG_WINDOW);
    localparam longint unsigned SUM_CAP = 64'd67108863;
    localparam int unsigned CNT_CAP = 2047;

    typedef struct {
        longint     stamp;
        int         key;
        int         client;
        int         amt;
    } booking_t;

    typedef struct packed {
        logic                 refused;
        logic [CNT_OUT_W-1:0] clients;
        logic [SUM_OUT_W-1:0] total;
    } tally_t;

    logic [CFG_W-1:0] window;
    booking_t         bookings[$];
    tally_t           tallies[$];
    int unsigned      pair_cnt[KEY_COUNT_DEF*CLIENT_IDS_DEF];
    int unsigned      key_cnt[KEY_COUNT_DEF];
    longint unsigned  key_sum[KEY_COUNT_DEF];

    function automatic tally_t predict_tally(logic is_query, longint stamp, int key,
                                             int client, int amt);
        tally_t   res;
        booking_t b;
        booking_t old;
        int       slot;
        longint   limit;
        res.refused = 1'b0;
        if (!is_query) begin
            limit = stamp - longint'(window);
            while (bookings.size() > 0 && bookings[0].stamp <= limit) begin
                old = bookings.pop_front();
                slot = old.key * CLIENT_IDS_DEF + old.client;
                if (pair_cnt[slot] > 0) begin
                    pair_cnt[slot]--;
                    if (pair_cnt[slot] == 0 && key_cnt[old.key] > 0)
                        key_cnt[old.key]--;
                end
                if (key_sum[old.key] >= old.amt)
                    key_sum[old.key] -= old.amt;
                else
                    key_sum[old.key] = 0;
            end
            if (bookings.size() >= QUEUE_DEPTH_DEF) begin
                res.refused = 1'b1;
            end else begin
                b.stamp = stamp;
                b.key = key;
                b.client = client;
                b.amt = amt;
                bookings.push_back(b);
                slot = key * CLIENT_IDS_DEF + client;
                if (pair_cnt[slot] == 0)
                    key_cnt[key]++;
                pair_cnt[slot]++;
                key_sum[key] += amt;
            end
        end
        res.clients = (key_cnt[key] > CNT_CAP) ? CNT_OUT_W'(CNT_CAP) : CNT_OUT_W'(key_cnt[key]);
        res.total = (key_sum[key] > SUM_CAP) ? SUM_OUT_W'(SUM_CAP) : SUM_OUT_W'(key_sum[key]);
        return res;
    endfunction

    initial
    begin
        window = WINDOW_RESET;
        errors = 0;
        outstanding = 0;
        foreach (pair_cnt[i]) pair_cnt[i] = 0;
        foreach (key_cnt[i]) key_cnt[i] = 0;
        foreach (key_sum[i]) key_sum[i] = 0;
    end

    always @(posedge clk)
    begin
        tally_t got;
        tally_t want;
        if (rst_n) begin
            if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
                window = pwdata;
            if (out_valid && out_ready) begin
                got = {status, distinct_clients, amount_total};
                if (tallies.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result transfer: %p", got);
                    errors++;
                end else begin
                    want = tallies.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("mismatch: expected st=%0d cnt=%0d sum=%0d, got st=%0d cnt=%0d sum=%0d",
                                     want.refused, want.clients, want.total,
                                     got.refused, got.clients, got.total);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                tallies.push_back(predict_tally(op, longint'(event_time), int'(key_index),
                                                int'(client_index), int'(amount)));
            outstanding = tallies.size();
        end
    end

endmodule

FILE: test/testbench.sv
// testbench: drives the sliding window key tally unit with directed and random
// bookings and queries under varying stalls; depends on swkt_pkg, tally_checker and the top level
module testbench;
    import swkt_pkg::*;

    localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'(4 * REG_WINDOW);
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam longint T_MIN = -(64'sd1 <<< 47);
    localparam longint T_MAX = (64'sd1 <<< 47) - 1;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [CFG_W-1:0]         pwdata;
    logic [CFG_W-1:0]         prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic                     op;
    logic signed [TIME_W-1:0] event_time;
    logic [KEY_IN_W-1:0]      key_index;
    logic [CLI_IN_W-1:0]      client_index;
    logic [AMT_W-1:0]         amount;
    logic                     out_valid;
    logic                     out_ready;
    logic                     status;
    logic [CNT_OUT_W-1:0]     distinct_clients;
    logic [SUM_OUT_W-1:0]     amount_total;
    int                       errors;
    int                       outstanding;

    int     send_idle;
    int     recv_stall;
    int     hold_asked;
    int     hold_served;
    int     hold_left;
    longint now_t;

    sliding_window_key_tally_unit DUT (.*);

    tally_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        hold_served = 0;
        hold_left = 0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= 400;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send(logic o, longint t, int k, int c, int a);
        @(negedge clk);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle);
        end
        op <= o;
        event_time <= t[TIME_W-1:0];
        key_index <= k[KEY_IN_W-1:0];
        client_index <= c[CLI_IN_W-1:0];
        amount <= a[AMT_W-1:0];
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_window(logic [CFG_W-1:0] w);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (30) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= WINDOW_ADDR;
        pwdata <= w;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_items(int n, longint step_max);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 20) begin
                send(OP_QUERY, {$urandom, $urandom}, $urandom, $urandom, $urandom);
            end else begin
                r = $urandom_range(99);
                if (r < 8)
                    now_t -= $urandom_range(0, 2 * int'(step_max) + 1);
                else
                    now_t += $urandom_range(0, int'(step_max));
                send(OP_RECORD, now_t,
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 7),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 15),
                     $urandom);
            end
        end
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 55; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 55; end
            default: begin send_idle = 29; recv_stall = 29; end
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = OP_RECORD;
        event_time = '0;
        key_index = '0;
        client_index = '0;
        amount = '0;
        out_ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_asked = 0;
        now_t = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, never-used key, repeat pair, time going back
        send(OP_RECORD, T_MIN, 0, 0, 0);
        send(OP_RECORD, T_MIN, 63, 1023, 65535);
        send(OP_QUERY, 0, 63, 0, 0);
        send(OP_QUERY, -1, 5, 1023, 65535);
        send(OP_RECORD, T_MAX, 63, 1023, 65535);
        send(OP_RECORD, T_MAX, 63, 1023, 1);
        send(OP_RECORD, T_MAX, 63, 7, 100);
        send(OP_RECORD, 0, 63, 8, 200);
        send(OP_QUERY, T_MAX, 63, 0, 0);
        send(OP_RECORD, 48'sh555555555555, 1, 2, 16'h5555);
        send(OP_RECORD, -48'sh2AAAAAAAAAAB, 1, 2, 16'hAAAA);
        write_window(32'hFFFFFFFF);
        send(OP_RECORD, 1000, 2, 3, 4);
        send(OP_RECORD, 1000 + 64'hFFFFFFFF, 2, 3, 5);
        write_window(0);
        send(OP_RECORD, 50, 3, 9, 11);
        send(OP_RECORD, 50, 3, 9, 12);
        send(OP_RECORD, 50, 3, 10, 13);
        send(OP_QUERY, 0, 3, 0, 0);

        now_t = 64'sd1 <<< 40;
        write_window(1);
        set_idling(0);
        random_items(120, 3);
        write_window(100);
        set_idling(1);
        random_items(120, 40);
        write_window(WINDOW_RESET);
        set_idling(2);
        random_items(120, 20000);
        write_window(0);
        set_idling(3);
        random_items(120, 2);

        // fill the queue past capacity, with the receiver holding off at the start
        now_t += 64'sd1 <<< 36;
        write_window(32'hFFFFFFFF);
        set_idling(0);
        hold_asked = hold_asked + 1;
        random_items(1350, 3);
        now_t += 64'sd1 <<< 34;
        set_idling(3);
        random_items(40, 3);
        write_window(5000);
        random_items(60, 2000);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
